// ===== design/domq_pkg.sv =====
package domq_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int TIME_BITS   = 48;
    localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_ENQUEUE = 2'd0,
        OP_POLL    = 2'd1,
        OP_QUIT    = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        STS_ACCEPTED     = 3'd0,
        STS_DROPPED      = 3'd1,
        STS_FULL         = 3'd2,
        STS_DELIVERED    = 3'd3,
        STS_NOT_DUE      = 3'd4,
        STS_EMPTY        = 3'd5,
        STS_QUIT_DONE    = 3'd6,
        STS_ALREADY_QUIT = 3'd7
    } status_t;

    typedef struct packed {
        op_t         operation;
        logic [15:0] message_id;
        logic [47:0] due_time;
        logic [47:0] now_time;
        logic        safely;
    } in_item_t;

    typedef struct packed {
        status_t     status;
        logic [15:0] out_message_id;
        logic [47:0] out_due_time;
        logic [47:0] wait_time;
    } result_t;

    typedef struct packed {
        logic [15:0]          id;
        logic [TIME_BITS-1:0] due;
    } entry_t;

    // read address selects
    typedef enum logic [1:0] {
        RS_HEAD    = 2'd0,
        RS_CNT_M1  = 2'd1,
        RS_IDX_M2  = 2'd2,
        RS_KEEP_P1 = 2'd3
    } rd_sel_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_INS_CMP,
        S_INS_WR,
        S_POLL_CMP,
        S_QUIT_CMP
    } state_t;

    typedef struct packed {
        logic    load;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    idx_init;
        logic    shift;
        logic    wr_front;
        logic    wr_at_idx;
        logic    pop;
        logic    quit_set;
        logic    clr_count;
        logic    keep_clr;
        logic    keep_inc;
        logic    keep_commit;
        logic    keep_commit1;
        logic    res_en;
        status_t res_status;
    } ctrl_cmd_t;

    typedef struct packed {
        op_t  op;
        logic safely;
        logic quit;
        logic full;
        logic empty;
        logic due_zero;
        logic ins_later;
        logic head_due;
        logic idx_one;
        logic keep_last;
    } dp_status_t;

endpackage

// ===== design/deadline_ordered_message_queue_unit.sv =====
// Channel   Ports                    Beat marker
// command   start, busy, in_item     start high while busy low
// result    done, result             done high for one cycle
//
// A command is latched, decoded the next cycle, and its result beat shows in the cycle after
// the last step: drop, full, front insert, plain quit and unused code end at decode; a poll
// adds a compare step. An enqueue with nonzero due time walks back from the tail one entry
// per cycle through the entry memory (one read, one write port); a safe quit walks
// forward from the head likewise. busy is high from the cycle after start
// until the result is computed. Reset clears count, head and quit flag at
// once; no clearing pass. The receiver cannot stall result beats.
module deadline_ordered_message_queue_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  domq_pkg::in_item_t in_item,
    output logic               busy,
    output logic               done,
    output domq_pkg::result_t  result
);

    domq_pkg::ctrl_cmd_t  cmd;
    domq_pkg::dp_status_t sts;

    domq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .busy  (busy),
        .cmd   (cmd)
    );

    domq_datapath u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_item (in_item),
        .cmd     (cmd),
        .sts     (sts),
        .done    (done),
        .result  (result)
    );

endmodule

// ===== design/domq_datapath.sv =====
module domq_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  domq_pkg::in_item_t   in_item,
    input  domq_pkg::ctrl_cmd_t  cmd,
    output domq_pkg::dp_status_t sts,
    output logic                 done,
    output domq_pkg::result_t    result
);

    localparam int AW = domq_pkg::ADDR_W;
    localparam int CW = domq_pkg::CNT_W;
    localparam int TW = domq_pkg::TIME_BITS;

    // physical slot of logical position off behind head
    function automatic logic [AW-1:0] slot_addr(input logic [AW-1:0] head,
                                                input logic [CW-1:0] off);
        logic [CW:0] sum;
        sum = (CW+1)'(head) + (CW+1)'(off);
        if (sum >= (CW+1)'(domq_pkg::QUEUE_DEPTH))
        begin
            sum = sum - (CW+1)'(domq_pkg::QUEUE_DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    domq_pkg::entry_t   mem [domq_pkg::QUEUE_DEPTH];
    domq_pkg::entry_t   rd_data_reg;
    domq_pkg::in_item_t item_reg;
    logic [AW-1:0]      head_reg, head_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      idx_reg, idx_next;
    logic [CW-1:0]      keep_reg, keep_next;
    logic               quit_reg, quit_next;
    logic               done_reg;
    domq_pkg::result_t  result_reg;

    logic [CW-1:0]      rd_off;
    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      head_dec;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    domq_pkg::entry_t   wr_data;
    domq_pkg::entry_t   new_entry;
    logic [TW-1:0]      due_in;
    logic [TW-1:0]      now_in;

    assign due_in    = item_reg.due_time[TW-1:0];
    assign now_in    = item_reg.now_time[TW-1:0];
    assign new_entry = '{id: item_reg.message_id, due: due_in};
    assign head_dec  = (head_reg == '0) ? AW'(domq_pkg::QUEUE_DEPTH - 1) : head_reg - 1'b1;

    // read address
    always_comb
    begin
        case (cmd.rd_sel)
            domq_pkg::RS_HEAD:    rd_off = '0;
            domq_pkg::RS_CNT_M1:  rd_off = count_reg - 1'b1;
            domq_pkg::RS_IDX_M2:  rd_off = idx_reg - CW'(2);
            domq_pkg::RS_KEEP_P1: rd_off = keep_reg + 1'b1;
            default:              rd_off = '0;
        endcase
        rd_addr = slot_addr(head_reg, rd_off);
    end

    // single write port
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = slot_addr(head_reg, idx_reg);
        wr_data = new_entry;
        if (cmd.wr_front)
        begin
            wr_en   = 1'b1;
            wr_addr = head_dec;
        end
        else if (cmd.shift)
        begin
            wr_en   = 1'b1;
            wr_data = rd_data_reg;
        end
        else if (cmd.wr_at_idx)
        begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
        if (cmd.load)
        begin
            item_reg <= in_item;
        end
    end

    // queue bookkeeping
    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        keep_next  = keep_reg;
        quit_next  = quit_reg;
        if (cmd.wr_front)
        begin
            head_next  = head_dec;
            count_next = count_reg + 1'b1;
        end
        if (cmd.wr_at_idx)
        begin
            count_next = count_reg + 1'b1;
        end
        if (cmd.idx_init)
        begin
            idx_next = count_reg;
        end
        if (cmd.shift)
        begin
            idx_next = idx_reg - 1'b1;
        end
        if (cmd.pop)
        begin
            head_next  = slot_addr(head_reg, CW'(1));
            count_next = count_reg - 1'b1;
        end
        if (cmd.quit_set)
        begin
            quit_next = 1'b1;
        end
        if (cmd.clr_count)
        begin
            count_next = '0;
        end
        if (cmd.keep_clr)
        begin
            keep_next = '0;
        end
        if (cmd.keep_inc)
        begin
            keep_next = keep_reg + 1'b1;
        end
        if (cmd.keep_commit)
        begin
            count_next = keep_reg;
        end
        if (cmd.keep_commit1)
        begin
            count_next = keep_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
            idx_reg   <= '0;
            keep_reg  <= '0;
            quit_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            keep_reg  <= keep_next;
            quit_reg  <= quit_next;
            done_reg  <= cmd.res_en;
        end
    end

    // result beat
    always_ff @(posedge clk)
    begin
        if (cmd.res_en)
        begin
            result_reg.status         <= cmd.res_status;
            result_reg.out_message_id <= '0;
            result_reg.out_due_time   <= '0;
            result_reg.wait_time      <= '0;
            if (cmd.res_status == domq_pkg::STS_DELIVERED)
            begin
                result_reg.out_message_id <= rd_data_reg.id;
                result_reg.out_due_time   <= 48'(rd_data_reg.due);
            end
            if (cmd.res_status == domq_pkg::STS_NOT_DUE)
            begin
                result_reg.wait_time <= 48'(rd_data_reg.due - now_in);
            end
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    // status to controller
    assign sts.op        = item_reg.operation;
    assign sts.safely    = item_reg.safely;
    assign sts.quit      = quit_reg;
    assign sts.full      = (count_reg == CW'(domq_pkg::QUEUE_DEPTH));
    assign sts.empty     = (count_reg == '0);
    assign sts.due_zero  = (due_in == '0);
    assign sts.ins_later = (rd_data_reg.due > due_in);
    assign sts.head_due  = (rd_data_reg.due <= now_in);
    assign sts.idx_one   = (idx_reg == CW'(1));
    assign sts.keep_last = ((keep_reg + 1'b1) == count_reg);

endmodule

// ===== design/domq_ctrl.sv =====
module domq_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  domq_pkg::dp_status_t sts,
    output logic                 busy,
    output domq_pkg::ctrl_cmd_t  cmd
);

    domq_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= domq_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != domq_pkg::S_IDLE);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            domq_pkg::S_IDLE:
            begin
                if (start)
                begin
                    state_next = domq_pkg::S_DECODE;
                end
            end
            domq_pkg::S_DECODE:
            begin
                state_next = domq_pkg::S_IDLE;
                case (sts.op)
                    domq_pkg::OP_ENQUEUE:
                    begin
                        if (!sts.quit && !sts.full && !sts.due_zero)
                        begin
                            state_next = sts.empty ? domq_pkg::S_INS_WR
                                                   : domq_pkg::S_INS_CMP;
                        end
                    end
                    domq_pkg::OP_POLL:
                    begin
                        if (!sts.quit && !sts.empty)
                        begin
                            state_next = domq_pkg::S_POLL_CMP;
                        end
                    end
                    domq_pkg::OP_QUIT:
                    begin
                        if (!sts.quit && sts.safely && !sts.empty)
                        begin
                            state_next = domq_pkg::S_QUIT_CMP;
                        end
                    end
                    default: state_next = domq_pkg::S_IDLE;
                endcase
            end
            domq_pkg::S_INS_CMP:
            begin
                if (!sts.ins_later)
                begin
                    state_next = domq_pkg::S_IDLE;
                end
                else if (sts.idx_one)
                begin
                    state_next = domq_pkg::S_INS_WR;
                end
            end
            domq_pkg::S_INS_WR:   state_next = domq_pkg::S_IDLE;
            domq_pkg::S_POLL_CMP: state_next = domq_pkg::S_IDLE;
            domq_pkg::S_QUIT_CMP:
            begin
                if (!sts.head_due || sts.keep_last)
                begin
                    state_next = domq_pkg::S_IDLE;
                end
            end
            default: state_next = domq_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd = '0;
        cmd.rd_sel     = domq_pkg::RS_HEAD;
        cmd.res_status = domq_pkg::STS_ACCEPTED;
        case (state_reg)
            domq_pkg::S_IDLE:
            begin
                cmd.load = start;
            end
            domq_pkg::S_DECODE:
            begin
                case (sts.op)
                    domq_pkg::OP_ENQUEUE:
                    begin
                        if (sts.quit)
                        begin
                            cmd.res_en     = 1'b1;
                            cmd.res_status = domq_pkg::STS_DROPPED;
                        end
                        else if (sts.full)
                        begin
                            cmd.res_en     = 1'b1;
                            cmd.res_status = domq_pkg::STS_FULL;
                        end
                        else if (sts.due_zero)
                        begin
                            cmd.wr_front = 1'b1;
                            cmd.res_en   = 1'b1;
                        end
                        else
                        begin
                            cmd.idx_init = 1'b1;
                            cmd.rd_en    = !sts.empty;
                            cmd.rd_sel   = domq_pkg::RS_CNT_M1;
                        end
                    end
                    domq_pkg::OP_POLL:
                    begin
                        if (sts.quit)
                        begin
                            cmd.res_en     = 1'b1;
                            cmd.res_status = domq_pkg::STS_ALREADY_QUIT;
                        end
                        else if (sts.empty)
                        begin
                            cmd.res_en     = 1'b1;
                            cmd.res_status = domq_pkg::STS_EMPTY;
                        end
                        else
                        begin
                            cmd.rd_en = 1'b1;
                        end
                    end
                    domq_pkg::OP_QUIT:
                    begin
                        if (sts.quit)
                        begin
                            cmd.res_en     = 1'b1;
                            cmd.res_status = domq_pkg::STS_ALREADY_QUIT;
                        end
                        else
                        begin
                            cmd.quit_set = 1'b1;
                            cmd.keep_clr = 1'b1;
                            if (!sts.safely)
                            begin
                                cmd.clr_count  = 1'b1;
                                cmd.res_en     = 1'b1;
                                cmd.res_status = domq_pkg::STS_QUIT_DONE;
                            end
                            else if (sts.empty)
                            begin
                                cmd.res_en     = 1'b1;
                                cmd.res_status = domq_pkg::STS_QUIT_DONE;
                            end
                            else
                            begin
                                cmd.rd_en = 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        cmd.res_en = 1'b1;
                    end
                endcase
            end
            domq_pkg::S_INS_CMP:
            begin
                if (sts.ins_later)
                begin
                    cmd.shift  = 1'b1;
                    cmd.rd_en  = !sts.idx_one;
                    cmd.rd_sel = domq_pkg::RS_IDX_M2;
                end
                else
                begin
                    cmd.wr_at_idx = 1'b1;
                    cmd.res_en    = 1'b1;
                end
            end
            domq_pkg::S_INS_WR:
            begin
                cmd.wr_at_idx = 1'b1;
                cmd.res_en    = 1'b1;
            end
            domq_pkg::S_POLL_CMP:
            begin
                cmd.res_en = 1'b1;
                if (sts.head_due)
                begin
                    cmd.pop        = 1'b1;
                    cmd.res_status = domq_pkg::STS_DELIVERED;
                end
                else
                begin
                    cmd.res_status = domq_pkg::STS_NOT_DUE;
                end
            end
            domq_pkg::S_QUIT_CMP:
            begin
                if (sts.head_due && !sts.keep_last)
                begin
                    cmd.keep_inc = 1'b1;
                    cmd.rd_en    = 1'b1;
                    cmd.rd_sel   = domq_pkg::RS_KEEP_P1;
                end
                else
                begin
                    cmd.keep_commit  = !sts.head_due;
                    cmd.keep_commit1 = sts.head_due;
                    cmd.res_en       = 1'b1;
                    cmd.res_status   = domq_pkg::STS_QUIT_DONE;
                end
            end
            default:
            begin
                cmd.res_en = 1'b0;
            end
        endcase
    end

endmodule

// ===== test/deadline_ordered_message_queue_unit_check.sv =====
`timescale 1ns / 100ps

module deadline_ordered_message_queue_unit_check (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  domq_pkg::in_item_t in_item,
    input  logic               done,
    input  domq_pkg::result_t  result,
    output int                 fail_count,
    output int                 pending_count
);

    // model of the queue contents
    logic [15:0]       q_id  [domq_pkg::QUEUE_DEPTH];
    logic [47:0]       q_due [domq_pkg::QUEUE_DEPTH];
    int                q_len;
    logic              quit_seen;
    domq_pkg::result_t expected_results[$];

    assign pending_count = expected_results.size();

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
        fail_count++;
    endtask

    // compute the result of one command and update the queue model
    function automatic domq_pkg::result_t queue_predict(input domq_pkg::in_item_t it);
        domq_pkg::result_t r;
        int pos;
        r = '0;
        r.status = domq_pkg::STS_ACCEPTED;
        case (it.operation)
            domq_pkg::OP_ENQUEUE:
            begin
                if (quit_seen)
                    r.status = domq_pkg::STS_DROPPED;
                else if (q_len >= domq_pkg::QUEUE_DEPTH)
                    r.status = domq_pkg::STS_FULL;
                else
                begin
                    pos = 0;
                    if (it.due_time != 0)
                        while (pos < q_len && q_due[pos] <= it.due_time)
                            pos++;
                    for (int k = q_len; k > pos; k--)
                    begin
                        q_id[k]  = q_id[k-1];
                        q_due[k] = q_due[k-1];
                    end
                    q_id[pos]  = it.message_id;
                    q_due[pos] = it.due_time;
                    q_len++;
                end
            end
            domq_pkg::OP_POLL:
            begin
                if (quit_seen)
                    r.status = domq_pkg::STS_ALREADY_QUIT;
                else if (q_len == 0)
                    r.status = domq_pkg::STS_EMPTY;
                else if (it.now_time < q_due[0])
                begin
                    r.status    = domq_pkg::STS_NOT_DUE;
                    r.wait_time = q_due[0] - it.now_time;
                end
                else
                begin
                    r.status         = domq_pkg::STS_DELIVERED;
                    r.out_message_id = q_id[0];
                    r.out_due_time   = q_due[0];
                    for (int k = 0; k < q_len - 1; k++)
                    begin
                        q_id[k]  = q_id[k+1];
                        q_due[k] = q_due[k+1];
                    end
                    q_len--;
                end
            end
            domq_pkg::OP_QUIT:
            begin
                if (quit_seen)
                    r.status = domq_pkg::STS_ALREADY_QUIT;
                else
                begin
                    quit_seen = 1'b1;
                    pos = 0;
                    if (it.safely)
                        while (pos < q_len && q_due[pos] <= it.now_time)
                            pos++;
                    q_len    = pos;
                    r.status = domq_pkg::STS_QUIT_DONE;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_len      = 0;
            quit_seen  = 1'b0;
            fail_count = 0;
            expected_results.delete();
        end
        else
        begin
            // result beat first: a new command cannot finish in its own cycle
            if (done)
            begin
                domq_pkg::result_t w;
                if (expected_results.size() == 0)
                    report_mismatch("unexpected beat", 64'(result.status), 64'd0);
                else
                begin
                    w = expected_results.pop_front();
                    if (result.status !== w.status)
                        report_mismatch("status", 64'(result.status), 64'(w.status));
                    if (result.out_message_id !== w.out_message_id)
                        report_mismatch("message id", 64'(result.out_message_id),
                                        64'(w.out_message_id));
                    if (result.out_due_time !== w.out_due_time)
                        report_mismatch("due time", 64'(result.out_due_time),
                                        64'(w.out_due_time));
                    if (result.wait_time !== w.wait_time)
                        report_mismatch("wait time", 64'(result.wait_time),
                                        64'(w.wait_time));
                end
            end
            if (start && !busy)
                expected_results.push_back(queue_predict(in_item));
        end
    end

endmodule

// ===== test/deadline_ordered_message_queue_unit_test.sv =====
`timescale 1ns / 100ps

module deadline_ordered_message_queue_unit_test;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    domq_pkg::in_item_t in_item = '0;
    logic               busy;
    logic               done;
    domq_pkg::result_t  result;
    int                 fail_count;
    int                 pending_count;
    int                 idle_pct;
    logic [47:0]        now_ms;

    deadline_ordered_message_queue_unit u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .in_item(in_item),
        .busy(busy), .done(done), .result(result)
    );

    deadline_ordered_message_queue_unit_check u_check (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
        .done(done), .result(result), .fail_count(fail_count),
        .pending_count(pending_count)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // one command beat, with random idle cycles ahead of it; busy only moves at
    // the rising edge, so the value seen at the falling edge holds for the next edge
    task automatic send_cmd(input domq_pkg::op_t op, input logic [15:0] id,
                            input logic [47:0] due, input logic [47:0] now,
                            input logic safe);
        while ($urandom_range(99) < idle_pct)
            @(negedge clk);
        while (busy)
            @(negedge clk);
        start   <= 1'b1;
        in_item <= '{operation: op, message_id: id, due_time: due, now_time: now,
                     safely: safe};
        @(negedge clk);
        start <= 1'b0;
    endtask

    function automatic logic [47:0] rand_time();
        return 48'({$urandom, $urandom});
    endfunction

    // wait for outstanding beats, then run on idle; the quit state is not cleared,
    // as there is no reset: a quit is sticky, so later enqueues are dropped and polls see already-quit
    task automatic drain();
        while (pending_count != 0)
            @(negedge clk);
        repeat (domq_pkg::QUEUE_DEPTH + 8) @(negedge clk);
    endtask

    // one session of mostly well-formed traffic near a moving clock
    task automatic random_traffic(input int n);
        int sel;
        for (int i = 0; i < n; i++)
        begin
            sel = $urandom_range(99);
            now_ms += 48'($urandom_range(40));
            if (sel < 2)
                send_cmd(domq_pkg::OP_NONE, 16'($urandom), rand_time(), rand_time(),
                         1'($urandom));
            else if (sel < 5)
                send_cmd(domq_pkg::OP_ENQUEUE, 16'($urandom), rand_time(), rand_time(),
                         1'($urandom));
            else if (sel < 10)
                send_cmd(domq_pkg::OP_ENQUEUE, 16'($urandom), 48'd0, 48'd0, 1'($urandom));
            else if (sel < 55)
                send_cmd(domq_pkg::OP_ENQUEUE, 16'($urandom),
                         48'(now_ms + 48'($urandom_range(200))), rand_time(),
                         1'($urandom));
            else if (sel < 98)
                send_cmd(domq_pkg::OP_POLL, 16'($urandom), rand_time(), now_ms,
                         1'($urandom));
            else
                send_cmd(domq_pkg::OP_POLL, 16'($urandom), rand_time(), rand_time(),
                         1'($urandom));
        end
    endtask

    initial
    begin
        #400000000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        idle_pct = 19;
        now_ms   = 48'd1000;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty poll, extremes, front insert, ties, fill to full
        send_cmd(domq_pkg::OP_POLL, 16'h0, 48'h0, 48'h0, 1'b0);
        send_cmd(domq_pkg::OP_NONE, 16'hFFFF, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b1);
        send_cmd(domq_pkg::OP_ENQUEUE, 16'hFFFF, 48'hFFFF_FFFF_FFFF, 48'h0, 1'b0);
        send_cmd(domq_pkg::OP_ENQUEUE, 16'h0001, 48'd500, 48'h0, 1'b0);
        send_cmd(domq_pkg::OP_ENQUEUE, 16'h0002, 48'd500, 48'h0, 1'b0);
        send_cmd(domq_pkg::OP_ENQUEUE, 16'h0003, 48'd0, 48'h0, 1'b0);
        send_cmd(domq_pkg::OP_POLL, 16'h0, 48'h0, 48'h0, 1'b0);
        send_cmd(domq_pkg::OP_POLL, 16'h0, 48'h0, 48'd100, 1'b0);
        send_cmd(domq_pkg::OP_POLL, 16'h0, 48'h0, 48'hFFFF_FFFF_FFFE, 1'b0);
        send_cmd(domq_pkg::OP_POLL, 16'h0, 48'h0, 48'hFFFF_FFFF_FFFF, 1'b0);
        for (int i = 0; i < domq_pkg::QUEUE_DEPTH + 2; i++)
            send_cmd(domq_pkg::OP_ENQUEUE, 16'($urandom), 48'(48'd1 + $urandom_range(300)),
                     rand_time(), 1'b0);

        // main random run across idle settings; the quits come after the first session
        random_traffic(400);
        send_cmd(domq_pkg::OP_QUIT, 16'h0, 48'h0, now_ms, 1'b1);
        send_cmd(domq_pkg::OP_QUIT, 16'h0, 48'h0, now_ms, 1'b0);
        send_cmd(domq_pkg::OP_POLL, 16'h0, 48'h0, now_ms, 1'b0);
        send_cmd(domq_pkg::OP_ENQUEUE, 16'h55, 48'd7, 48'h0, 1'b0);
        idle_pct = 58;
        random_traffic(300);
        idle_pct = 0;
        random_traffic(400);

        drain();
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
